// File: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Register indexes, fixed-point constants and pipeline depth for the
// pressure sensor compensation block.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Pipeline depth, input register to output register
  localparam int NUM_STAGES = 13;

  // Configuration register indexes
  localparam logic [2:0] REG_SENS       = 3'd0;
  localparam logic [2:0] REG_OFFSET     = 3'd1;
  localparam logic [2:0] REG_TCS        = 3'd2;
  localparam logic [2:0] REG_TCO        = 3'd3;
  localparam logic [2:0] REG_REF_TEMP   = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE = 3'd5;
  localparam logic [2:0] REG_SURFACE    = 3'd6;

  localparam logic [10:0] SURFACE_RESET = 11'd985;

  // Temperature in 0.01 degC at 20 degC
  localparam logic signed [18:0] TEMP_REF = 19'sd2000;

  // Saturation bounds for temperature before the divide by 100
  localparam logic signed [18:0] TT_MIN    = -19'sd4099;
  localparam logic signed [18:0] TT_MAX    = 19'sd8599;
  localparam logic signed [7:0]  T_DEG_MIN = -8'sd40;
  localparam logic signed [7:0]  T_DEG_MAX = 8'sd85;
  // floor(n / 100) = (n * 5243) >> 19 for n below 43690
  localparam logic [12:0] TEMP_RECIP = 13'd5243;

  // Saturation bound for pressure in 0.1 mbar before the divide by 10
  localparam logic signed [27:0] P_MAX      = 28'sd400009;
  localparam logic [15:0]        P_MBAR_MAX = 16'd40000;
  // floor(n / 10) = (n * 838861) >> 23 for n below 4194304
  localparam logic [19:0] PRES_RECIP = 20'd838861;

  // Q16 form of 1 / 0.983615
  localparam logic signed [17:0] DEPTH_SCALE_Q16 = 18'sd66628;
  localparam logic signed [18:0] DEPTH_MIN       = -19'sd2100;
  localparam logic signed [18:0] DEPTH_MAX       = 19'sd41000;

endpackage

// File: rtl/pressure_sensor_compensation.sv
// An accepted sample passes through stage registers 0 to 12, the last of which is the output register.
// Throughput: one sample per cycle while result_stall is low; stages 1 and 5 each hold several multipliers, and
// the pressure product is split into two partial products over two stages.
// A stalled stage holds its contents; earlier empty stages keep filling.
// Reset clears all stage valid bits and loads the calibration registers with zero
// and the surface pressure with 985 mbar.
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order temperature compensation of raw barometric conversions, giving
// temperature in degC, pressure in mbar and depth below the surface.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [7:0]  temperature_deg,
  output logic [15:0]        pressure_mbar,
  output logic signed [16:0] depth_cm,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Calibration registers
  logic [15:0] sens_coeff;
  logic [15:0] offset_coeff;
  logic [15:0] tcs_coeff;
  logic [15:0] tco_coeff;
  logic [15:0] ref_temp_coeff;
  logic [15:0] temp_slope_coeff;
  logic [10:0] surface_pressure;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff       <= '0;
      offset_coeff     <= '0;
      tcs_coeff        <= '0;
      tco_coeff        <= '0;
      ref_temp_coeff   <= '0;
      temp_slope_coeff <= '0;
      surface_pressure <= SURFACE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS:       sens_coeff       <= cfg_data;
        REG_OFFSET:     offset_coeff     <= cfg_data;
        REG_TCS:        tcs_coeff        <= cfg_data;
        REG_TCO:        tco_coeff        <= cfg_data;
        REG_REF_TEMP:   ref_temp_coeff   <= cfg_data;
        REG_TEMP_SLOPE: temp_slope_coeff <= cfg_data;
        REG_SURFACE:    surface_pressure <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = !result_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= sample_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign sample_stall = !en[0];
  assign result_valid = vld[NUM_STAGES-1];

  // Stage registers
  logic signed [24:0] s0_dt;
  logic [23:0]        s0_d1;

  logic signed [41:0] s1_t6, s1_o4, s1_s3;
  logic [47:0]        s1_dtsq;
  logic [23:0]        s1_d1;

  logic signed [18:0] s2_dev;
  logic               s2_low;
  logic [16:0]        s2_ti;
  logic signed [35:0] s2_off;
  logic signed [33:0] s2_sens;
  logic [23:0]        s2_d1;

  logic [33:0]        s3_sq;
  logic               s3_low;
  logic signed [35:0] s3_off;
  logic signed [33:0] s3_sens;
  logic signed [18:0] s3_tt;
  logic [23:0]        s3_d1;

  logic signed [36:0] s4_off2;
  logic signed [35:0] s4_sens2;
  logic [23:0]        s4_d1;
  logic               s4_tneg, s4_tlo, s4_thi;
  logic [13:0]        s4_tabs;

  logic [41:0]        s5_pplo;
  logic signed [42:0] s5_pphi;
  logic signed [36:0] s5_off2;
  logic signed [7:0]  s5_tdeg;

  logic signed [60:0] s6_prod;
  logic signed [36:0] s6_off2;
  logic signed [7:0]  s6_tdeg;

  logic signed [39:0] s7_q1;
  logic signed [36:0] s7_off2;
  logic signed [7:0]  s7_tdeg;

  logic signed [40:0] s8_numer;
  logic signed [7:0]  s8_tdeg;

  logic               s9_pzero, s9_psat;
  logic [18:0]        s9_pn;
  logic signed [7:0]  s9_tdeg;

  logic [15:0]        s10_pm;
  logic signed [7:0]  s10_tdeg;

  logic signed [34:0] s11_dp;
  logic [15:0]        s11_pm;
  logic signed [7:0]  s11_tdeg;

  // Stage 0: dT
  logic signed [24:0] dt_c;
  assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp_coeff, 8'h00});

  // Stage 1: products of dT
  logic signed [41:0] t6_prod, o4_prod, s3_prod;
  logic signed [49:0] sq_prod;
  assign t6_prod = s0_dt * $signed({1'b0, temp_slope_coeff});
  assign o4_prod = s0_dt * $signed({1'b0, tco_coeff});
  assign s3_prod = s0_dt * $signed({1'b0, tcs_coeff});
  assign sq_prod = s0_dt * s0_dt;

  // Stage 2: truncate toward zero, first-order OFF and SENS, Ti
  logic signed [41:0] t6_adj, o4_adj, s3_adj;
  logic signed [18:0] dev_c;
  logic signed [34:0] o4_q;
  logic signed [33:0] s3_q;
  logic signed [35:0] off_c;
  logic signed [33:0] sens_c;
  logic [49:0]        dtsq3;
  logic [16:0]        ti_c;

  assign t6_adj = s1_t6 + $signed({19'b0, {23{s1_t6[41]}}});
  assign dev_c  = t6_adj[41:23];
  assign o4_adj = s1_o4 + $signed({35'b0, {7{s1_o4[41]}}});
  assign o4_q   = o4_adj[41:7];
  assign s3_adj = s1_s3 + $signed({34'b0, {8{s1_s3[41]}}});
  assign s3_q   = s3_adj[41:8];
  assign off_c  = $signed({4'b0, offset_coeff, 16'h0000}) + $signed({o4_q[34], o4_q});
  assign sens_c = $signed({3'b0, sens_coeff, 15'h0000}) + s3_q;
  assign dtsq3  = {2'b0, s1_dtsq} + {1'b0, s1_dtsq, 1'b0};
  // below 20 degC: 3*dT^2 / 2^33, else dT^2 / 2^36
  assign ti_c   = dev_c[18] ? dtsq3[49:33] : {5'b0, s1_dtsq[47:36]};

  // Stage 3: square of TEMP - 2000, TEMP - Ti
  logic signed [37:0] dev_sq;
  logic signed [18:0] tt_c;
  assign dev_sq = s2_dev * s2_dev;
  assign tt_c   = TEMP_REF + s2_dev - $signed({2'b0, s2_ti});

  // Stage 4: second-order OFF and SENS, temperature saturation
  logic [35:0]        sq3;
  logic [36:0]        sq5;
  logic [34:0]        offi_c;
  logic [33:0]        sensi_c;
  logic signed [36:0] off2_c;
  logic signed [35:0] sens2_c;
  logic signed [18:0] tt_abs;

  assign sq3     = {2'b0, s3_sq} + {1'b0, s3_sq, 1'b0};
  assign sq5     = {3'b0, s3_sq} + {1'b0, s3_sq, 2'b00};
  assign offi_c  = s3_low ? sq3[35:1] : {5'b0, s3_sq[33:4]};
  assign sensi_c = s3_low ? sq5[36:3] : '0;
  assign off2_c  = $signed({s3_off[35], s3_off}) - $signed({2'b0, offi_c});
  assign sens2_c = $signed({{2{s3_sens[33]}}, s3_sens}) - $signed({2'b0, sensi_c});
  assign tt_abs  = s3_tt[18] ? -s3_tt : s3_tt;

  // Stage 5: partial products of D1 * SENS, temperature divide by 100
  logic [41:0]        pplo_c;
  logic signed [42:0] pphi_c;
  logic [26:0]        tq_prod;
  logic signed [7:0]  tq;
  logic signed [7:0]  tdeg_c;

  assign pplo_c  = s4_d1 * s4_sens2[17:0];
  assign pphi_c  = $signed({1'b0, s4_d1}) * $signed(s4_sens2[35:18]);
  assign tq_prod = s4_tabs * TEMP_RECIP;
  assign tq      = tq_prod[26:19];

  always_comb begin
    priority if (s4_tlo) tdeg_c = T_DEG_MIN;
    else if (s4_thi)     tdeg_c = T_DEG_MAX;
    else if (s4_tneg)    tdeg_c = -tq;
    else                 tdeg_c = tq;
  end

  // Stage 6: combine partial products
  logic signed [60:0] prod_c;
  assign prod_c = $signed({s5_pphi, 18'h00000}) + $signed({19'b0, s5_pplo});

  // Stage 7: D1 * SENS / 2^21
  logic signed [60:0] q1_adj;
  assign q1_adj = s6_prod + $signed({40'b0, {21{s6_prod[60]}}});

  // Stage 8: subtract OFF
  logic signed [40:0] numer_c;
  assign numer_c = $signed({s7_q1[39], s7_q1}) - $signed({{4{s7_off2[36]}}, s7_off2});

  // Stage 9: P in 0.1 mbar, range check
  logic signed [40:0] n_adj;
  logic signed [27:0] p_c;
  assign n_adj = s8_numer + $signed({28'b0, {13{s8_numer[40]}}});
  assign p_c   = n_adj[40:13];

  // Stage 10: divide by 10
  logic [38:0] pq_prod;
  logic [15:0] pm_c;
  assign pq_prod = s9_pn * PRES_RECIP;

  always_comb begin
    priority if (s9_psat) pm_c = P_MBAR_MAX;
    else if (s9_pzero)    pm_c = '0;
    else                  pm_c = pq_prod[38:23];
  end

  // Stage 11: pressure above surface times depth scale
  logic signed [16:0] diff_c;
  logic signed [34:0] dp_c;
  assign diff_c = $signed({1'b0, s10_pm}) - $signed({6'b0, surface_pressure});
  assign dp_c   = diff_c * DEPTH_SCALE_Q16;

  // Stage 12: scale down and saturate depth
  logic signed [34:0] dq_adj;
  logic signed [18:0] dq;
  logic signed [16:0] depth_c;
  assign dq_adj = s11_dp + $signed({19'b0, {16{s11_dp[34]}}});
  assign dq     = dq_adj[34:16];

  always_comb begin
    priority if (dq < DEPTH_MIN) depth_c = DEPTH_MIN[16:0];
    else if (dq > DEPTH_MAX)     depth_c = DEPTH_MAX[16:0];
    else                         depth_c = dq[16:0];
  end

  // Payload registers: each stage loads when it advances
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dt <= dt_c;
      s0_d1 <= raw_pressure;
    end
    if (en[1]) begin
      s1_t6   <= t6_prod;
      s1_o4   <= o4_prod;
      s1_s3   <= s3_prod;
      s1_dtsq <= sq_prod[47:0];
      s1_d1   <= s0_d1;
    end
    if (en[2]) begin
      s2_dev  <= dev_c;
      s2_low  <= dev_c[18];
      s2_ti   <= ti_c;
      s2_off  <= off_c;
      s2_sens <= sens_c;
      s2_d1   <= s1_d1;
    end
    if (en[3]) begin
      s3_sq   <= dev_sq[33:0];
      s3_low  <= s2_low;
      s3_off  <= s2_off;
      s3_sens <= s2_sens;
      s3_tt   <= tt_c;
      s3_d1   <= s2_d1;
    end
    if (en[4]) begin
      s4_off2  <= off2_c;
      s4_sens2 <= sens2_c;
      s4_d1    <= s3_d1;
      s4_tneg  <= s3_tt[18];
      s4_tlo   <= s3_tt < TT_MIN;
      s4_thi   <= s3_tt > TT_MAX;
      s4_tabs  <= tt_abs[13:0];
    end
    if (en[5]) begin
      s5_pplo <= pplo_c;
      s5_pphi <= pphi_c;
      s5_off2 <= s4_off2;
      s5_tdeg <= tdeg_c;
    end
    if (en[6]) begin
      s6_prod <= prod_c;
      s6_off2 <= s5_off2;
      s6_tdeg <= s5_tdeg;
    end
    if (en[7]) begin
      s7_q1   <= q1_adj[60:21];
      s7_off2 <= s6_off2;
      s7_tdeg <= s6_tdeg;
    end
    if (en[8]) begin
      s8_numer <= numer_c;
      s8_tdeg  <= s7_tdeg;
    end
    if (en[9]) begin
      s9_pzero <= p_c[27];
      s9_psat  <= !p_c[27] && (p_c > P_MAX);
      s9_pn    <= p_c[18:0];
      s9_tdeg  <= s8_tdeg;
    end
    if (en[10]) begin
      s10_pm   <= pm_c;
      s10_tdeg <= s9_tdeg;
    end
    if (en[11]) begin
      s11_dp   <= dp_c;
      s11_pm   <= s10_pm;
      s11_tdeg <= s10_tdeg;
    end
    if (en[12]) begin
      depth_cm        <= depth_c;
      pressure_mbar   <= s11_pm;
      temperature_deg <= s11_tdeg;
    end
  end

endmodule
